>>> design/btlv_pkg.sv
// Shared types and constants for the BER TLV header length parser.
// No dependencies; every design file refers to this package by scoped names.

package btlv_pkg;

    // One header byte with its framing mark and the receive buffer fill count
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_start;
        logic [16:0] buffered_count;
    } in_item_t;

    // One parse outcome
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  header_length;
        logic [31:0] total_length;
    } out_item_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [7:0] TAG_LOW_MASK  = 8'h1f;
    localparam logic [7:0] LEN_LONG_FORM = 8'h80;
    localparam logic [7:0] LEN_RESERVED  = 8'hff;
    localparam logic [3:0] HDR_LEN_MAX   = 4'hf;

endpackage

>>> design/btlv_parser.sv
// Header parser state machine: holds the per-element state and decodes one byte
// per advance. Depends on btlv_pkg for item types and status codes.

module btlv_parser #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int MAX_TAG_BYTES    = 6,
    parameter int BUFFER_BYTES     = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  btlv_pkg::in_item_t  item,
    output logic                result_valid,
    output btlv_pkg::out_item_t result
);

    // Largest header: full tag, length-form byte, leading zero plus length bytes
    localparam int POS_W = $clog2(MAX_TAG_BYTES + MAX_LENGTH_BYTES + 3);
    localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 2);
    localparam int CNT_W = 25;

    localparam logic [CNT_W-1:0] BUF_MAX  = CNT_W'(BUFFER_BYTES);
    localparam logic [POS_W-1:0] TAG_MAX  = POS_W'(MAX_TAG_BYTES);
    localparam logic [LBL_W-1:0] LBL_MAX  = LBL_W'(MAX_LENGTH_BYTES);
    localparam logic [6:0]       FORM_MAX = 7'(MAX_LENGTH_BYTES + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG_FIRST,
        PH_TAG_MORE,
        PH_LEN_FORM,
        PH_LEN_BYTES
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LBL_W-1:0]   lbl_reg, lbl_next;
    logic [31:0]        acc_reg, acc_next;
    logic               pend_reg, pend_next;

    phase_t             cur_phase;
    logic [POS_W-1:0]   cur_pos;
    logic [LBL_W-1:0]   cur_lbl;
    logic [31:0]        cur_acc;
    logic               cur_pend;

    logic [CNT_W-1:0]   cnt_ext;
    logic [CNT_W-1:0]   cnt_sat;
    logic [POS_W-1:0]   pos_inc;
    logic [7:0]         b;
    logic [31:0]        acc_shift;
    logic [LBL_W-1:0]   lbl_dec;
    logic [7:0]         pos8;
    logic [3:0]         hdr_len;
    logic               do_finish;
    logic [31:0]        fin_content;
    logic [32:0]        fin_total;

    assign b         = item.data_byte;
    assign cnt_ext   = CNT_W'(item.buffered_count);
    assign cnt_sat   = (cnt_ext > BUF_MAX) ? BUF_MAX : cnt_ext;

    // A frame start drops any header in progress and opens a new tag
    assign cur_phase = item.frame_start ? PH_TAG_FIRST : phase_reg;
    assign cur_pos   = item.frame_start ? '0 : pos_reg;
    assign cur_lbl   = item.frame_start ? '0 : lbl_reg;
    assign cur_acc   = item.frame_start ? '0 : acc_reg;
    assign cur_pend  = item.frame_start ? 1'b0 : pend_reg;

    assign pos_inc   = cur_pos + POS_W'(1);
    assign acc_shift = {cur_acc[23:0], b};
    assign lbl_dec   = cur_lbl - LBL_W'(1);
    assign pos8      = 8'(pos_inc);
    assign hdr_len   = (pos8 > 8'(btlv_pkg::HDR_LEN_MAX)) ? btlv_pkg::HDR_LEN_MAX : pos8[3:0];
    assign fin_total = {1'b0, fin_content} + 33'(pos_inc);

    always_comb
    begin
        phase_next   = cur_phase;
        pos_next     = cur_pos;
        lbl_next     = cur_lbl;
        acc_next     = cur_acc;
        pend_next    = cur_pend;
        result_valid = 1'b0;
        result       = '0;
        do_finish    = 1'b0;
        fin_content  = '0;

        if (cur_phase == PH_IDLE)
        begin
            // drop stray bytes between elements
        end
        else if (cnt_sat < CNT_W'(pos_inc))
        begin
            result_valid  = 1'b1;
            result.status = btlv_pkg::ST_OVERRUN;
            phase_next    = PH_IDLE;
        end
        else
        begin
            pos_next = pos_inc;
            unique case (cur_phase)
                PH_TAG_FIRST:
                begin
                    if ((b & btlv_pkg::TAG_LOW_MASK) == btlv_pkg::TAG_LOW_MASK)
                        phase_next = PH_TAG_MORE;
                    else
                        phase_next = PH_LEN_FORM;
                end
                PH_TAG_MORE:
                begin
                    if (!b[7])
                        phase_next = PH_LEN_FORM;
                    else if (pos_inc >= TAG_MAX)
                    begin
                        result_valid         = 1'b1;
                        result.status        = btlv_pkg::ST_BAD;
                        result.header_length = hdr_len;
                        phase_next           = PH_IDLE;
                    end
                end
                PH_LEN_FORM:
                begin
                    if (b == btlv_pkg::LEN_RESERVED || b == btlv_pkg::LEN_LONG_FORM
                        || (b[7] && b[6:0] > FORM_MAX))
                    begin
                        result_valid         = 1'b1;
                        result.status        = btlv_pkg::ST_BAD;
                        result.header_length = hdr_len;
                        phase_next           = PH_IDLE;
                    end
                    else if (!b[7])
                    begin
                        do_finish   = 1'b1;
                        fin_content = 32'(b);
                    end
                    else
                    begin
                        lbl_next   = LBL_W'(b[6:0]);
                        pend_next  = (b[6:0] > 7'd1);
                        acc_next   = '0;
                        phase_next = PH_LEN_BYTES;
                    end
                end
                PH_LEN_BYTES:
                begin
                    pend_next = 1'b0;
                    if (cur_pend && b == 8'd0)
                    begin
                        // skip one leading zero length byte
                        lbl_next = lbl_dec;
                        if (lbl_dec > LBL_MAX)
                        begin
                            result_valid         = 1'b1;
                            result.status        = btlv_pkg::ST_BAD;
                            result.header_length = hdr_len;
                            phase_next           = PH_IDLE;
                        end
                    end
                    else if (cur_lbl > LBL_MAX || cur_lbl == '0 || cur_acc[31:24] != 8'd0)
                    begin
                        result_valid         = 1'b1;
                        result.status        = btlv_pkg::ST_BAD;
                        result.header_length = hdr_len;
                        phase_next           = PH_IDLE;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        lbl_next = lbl_dec;
                        if (lbl_dec == '0)
                        begin
                            do_finish   = 1'b1;
                            fin_content = acc_shift;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_finish)
            begin
                result_valid         = 1'b1;
                result.header_length = hdr_len;
                phase_next           = PH_IDLE;
                if (fin_total[32])
                    result.status = btlv_pkg::ST_BAD;
                else
                begin
                    result.total_length = fin_total[31:0];
                    if (33'(cnt_sat) < fin_total)
                        result.status = btlv_pkg::ST_OVERRUN;
                    else
                        result.status = btlv_pkg::ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            lbl_reg   <= '0;
            acc_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            lbl_reg   <= lbl_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> design/ber_tlv_header_length_parser_core.sv
// Top level of the BER TLV header length parser: input register, parser, result register.
// Depends on btlv_pkg and btlv_parser.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------
//   bytes    | byte_valid / byte_ready     | byte_item   (in_item_t)
//   results  | result_valid / result_ready | result_item (out_item_t)
//
// One byte per cycle sustained while results are taken; a byte's result is loaded into the
// result register when the byte leaves the input register (the parser's single decode step).
// The parser state advances once per byte, so throughput is set by that one update.
// A stalled result holds the result register; one more byte may wait in the input register.
// rst_n clears the handshake state and returns the parser to idle.

module ber_tlv_header_length_parser_core #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int MAX_TAG_BYTES    = 6,
    parameter int BUFFER_BYTES     = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  btlv_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_ready,
    output btlv_pkg::out_item_t result_item
);

    logic                in_vld_reg;
    btlv_pkg::in_item_t  in_item_reg;
    logic                out_vld_reg;
    btlv_pkg::out_item_t out_item_reg;

    logic                advance;
    logic                take;
    logic                res_valid;
    btlv_pkg::out_item_t res;

    // Decode the held byte once the result register is free or draining
    assign advance      = in_vld_reg && (!out_vld_reg || result_ready);
    assign take         = byte_valid && byte_ready;
    assign byte_ready   = !in_vld_reg || advance;
    assign result_valid = out_vld_reg;
    assign result_item  = out_item_reg;

    btlv_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .MAX_TAG_BYTES    (MAX_TAG_BYTES),
        .BUFFER_BYTES     (BUFFER_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (in_item_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance && res_valid)
                out_vld_reg <= 1'b1;
            else if (result_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= byte_item;
        if (advance && res_valid)
            out_item_reg <= res;
    end

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.status <= btlv_pkg::ST_BAD)
        else $error("undefined status code on result");

    a_bad_no_total: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.status == btlv_pkg::ST_BAD)
        |-> result_item.total_length == 32'd0)
        else $error("bad length result carries a total");

    a_ok_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.status == btlv_pkg::ST_OK)
        |-> (result_item.header_length >= 4'd2
             && result_item.total_length >= 32'(result_item.header_length)))
        else $error("ok result with impossible header or total length");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_item_reg)))
        else $error("held byte lost while parser stalled");

endmodule

>>> sim/ber_tlv_header_length_parser_core_tb.sv
// Self-checking testbench for ber_tlv_header_length_parser_core: random and directed BER headers.
// Depends on btlv_pkg and the parser RTL; predicts each result in step with accepted bytes.

module ber_tlv_header_length_parser_core_tb;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int MAX_TAG_BYTES    = 6;
    localparam int BUFFER_BYTES     = 65536;
    localparam int STALL_LIMIT      = 1000;
    localparam int TAIL_CYCLES      = 20;
    localparam int ITEM_TARGET      = 400;

    typedef enum logic [2:0]
    {
        PH_IDLE,
        PH_TAG_FIRST,
        PH_TAG_MORE,
        PH_LEN_FORM,
        PH_LEN_BYTES
    } parse_phase_t;

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_ready;
    btlv_pkg::in_item_t  byte_item;
    logic                result_valid;
    logic                result_ready;
    btlv_pkg::out_item_t result_item;

    btlv_pkg::in_item_t  pending_bytes[$];
    btlv_pkg::out_item_t headers_due[$];
    int unsigned stimulus_count = 0;
    int unsigned bytes_in       = 0;
    int unsigned idle_cycles    = 0;
    int unsigned error_count    = 0;
    bit          byte_sent      = 1'b0;

    // Predicted parser state
    parse_phase_t ph           = PH_IDLE;
    int unsigned  hdr_pos      = 0;
    int unsigned  len_left     = 0;
    logic [31:0]  len_acc      = '0;
    bit           lead_zero_ok = 1'b0;

    ber_tlv_header_length_parser_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .MAX_TAG_BYTES    (MAX_TAG_BYTES),
        .BUFFER_BYTES     (BUFFER_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic emit_header(input logic [1:0] st, input int unsigned hdr,
                               input logic [31:0] tot, output btlv_pkg::out_item_t res);
        res.status        = st;
        res.header_length = (hdr > 15) ? btlv_pkg::HDR_LEN_MAX : hdr[3:0];
        res.total_length  = tot;
        ph                = PH_IDLE;
    endtask

    task automatic close_header(input longint unsigned content, input longint unsigned cnt,
                                output btlv_pkg::out_item_t res);
        longint unsigned total;
        total = content + 64'(hdr_pos);
        if (total > 64'hffff_ffff)
            emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
        else if (cnt < total)
            emit_header(btlv_pkg::ST_OVERRUN, hdr_pos, total[31:0], res);
        else
            emit_header(btlv_pkg::ST_OK, hdr_pos, total[31:0], res);
    endtask

    // Advance the predicted parser by one byte; a result exists once it drops to idle
    task automatic decode_header_byte(input btlv_pkg::in_item_t it, output bit produced,
                                      output btlv_pkg::out_item_t res);
        logic [7:0]      b;
        longint unsigned cnt;
        longint unsigned acc;
        int unsigned     n;
        bit              skipped;
        b        = it.data_byte;
        cnt      = 64'(it.buffered_count);
        produced = 1'b0;
        res      = '0;
        skipped  = 1'b0;
        if (cnt > 64'(BUFFER_BYTES))
            cnt = 64'(BUFFER_BYTES);
        if (it.frame_start)
        begin
            ph           = PH_TAG_FIRST;
            hdr_pos      = 0;
            len_left     = 0;
            len_acc      = '0;
            lead_zero_ok = 1'b0;
        end
        if (ph == PH_IDLE)
            return;
        if (cnt < 64'(hdr_pos) + 64'd1)
        begin
            emit_header(btlv_pkg::ST_OVERRUN, 0, '0, res);
            produced = 1'b1;
            return;
        end
        hdr_pos++;
        case (ph)
            PH_TAG_FIRST:
                ph = ((b & btlv_pkg::TAG_LOW_MASK) == btlv_pkg::TAG_LOW_MASK)
                     ? PH_TAG_MORE : PH_LEN_FORM;
            PH_TAG_MORE:
                if (!b[7])
                    ph = PH_LEN_FORM;
                else if (hdr_pos >= MAX_TAG_BYTES)
                    emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
            PH_LEN_FORM:
                if (b == btlv_pkg::LEN_RESERVED || b == btlv_pkg::LEN_LONG_FORM)
                    emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
                else if (b < btlv_pkg::LEN_LONG_FORM)
                    close_header(64'(b), cnt, res);
                else
                begin
                    n = 32'(b[6:0]);
                    if (n > MAX_LENGTH_BYTES + 1)
                        emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
                    else
                    begin
                        len_left     = n;
                        lead_zero_ok = (n > 1);
                        len_acc      = '0;
                        ph           = PH_LEN_BYTES;
                    end
                end
            PH_LEN_BYTES:
            begin
                if (lead_zero_ok)
                begin
                    lead_zero_ok = 1'b0;
                    if (b == 8'h00)
                    begin
                        skipped = 1'b1;
                        len_left--;
                        if (len_left > MAX_LENGTH_BYTES)
                            emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
                    end
                end
                if (!skipped)
                begin
                    if (len_left > MAX_LENGTH_BYTES || len_left == 0)
                        emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
                    else
                    begin
                        acc = 64'(len_acc) * 64'd256 + 64'(b);
                        if (acc > 64'hffff_ffff)
                            emit_header(btlv_pkg::ST_BAD, hdr_pos, '0, res);
                        else
                        begin
                            len_acc = acc[31:0];
                            len_left--;
                            if (len_left == 0)
                                close_header(64'(len_acc), cnt, res);
                        end
                    end
                end
            end
            default:
                ;
        endcase
        produced = (ph == PH_IDLE);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fs, input logic [16:0] cnt);
        btlv_pkg::in_item_t it;
        it.data_byte      = b;
        it.frame_start    = fs;
        it.buffered_count = cnt;
        pending_bytes.push_back(it);
        stimulus_count++;
    endtask

    // Monitor: predict on accepted bytes, check accepted results
    always @(posedge clk)
    begin
        bit                  produced;
        btlv_pkg::out_item_t predicted;
        btlv_pkg::out_item_t want;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                decode_header_byte(byte_item, produced, predicted);
                if (produced)
                    headers_due.push_back(predicted);
                bytes_in++;
                byte_sent = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                if (headers_due.size() == 0)
                begin
                    $error("unexpected result: status %0d header_length %0d total_length %0d",
                           result_item.status, result_item.header_length,
                           result_item.total_length);
                    error_count++;
                end
                else
                begin
                    want = headers_due.pop_front();
                    if (result_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result_item.status);
                        error_count++;
                    end
                    if (result_item.header_length !== want.header_length)
                    begin
                        $error("header_length: expected %0d, got %0d",
                               want.header_length, result_item.header_length);
                        error_count++;
                    end
                    if (result_item.total_length !== want.total_length)
                    begin
                        $error("total_length: expected %0d, got %0d",
                               want.total_length, result_item.total_length);
                        error_count++;
                    end
                end
            end
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Driver: change inputs on the falling edge; no idling while in the calm window
    always @(negedge clk)
    begin
        bit calm;
        if (rst_n)
        begin
            calm = (bytes_in >= 150 && bytes_in < 250);
            if (!byte_valid || byte_sent)
            begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 30))
                begin
                    byte_item  <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
            byte_sent = 1'b0;
            result_ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned r;
        int unsigned n;
        int unsigned k;
        bit          lz;
        logic [16:0] cnt;
        logic [7:0]  b;

        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_item    = '0;
        result_ready = 1'b0;

        // High tag number form, short length at its top value, clamped buffer count
        queue_byte(8'h1f, 1'b1, 17'h1ffff);
        queue_byte(8'h01, 1'b0, 17'h1ffff);
        queue_byte(8'h7f, 1'b0, 17'h1ffff);
        // Byte while idle: ignored
        queue_byte(8'hff, 1'b0, 17'd0);
        // Restart mid-header, then the 0x80 length byte
        queue_byte(8'h30, 1'b1, 17'd100);
        queue_byte(8'h30, 1'b1, 17'd100);
        queue_byte(8'h80, 1'b0, 17'd100);
        // Reserved 0xff length byte
        queue_byte(8'h04, 1'b1, 17'd100);
        queue_byte(8'hff, 1'b0, 17'd100);
        // Byte not buffered
        queue_byte(8'h02, 1'b1, 17'd0);
        // Short buffer at the end: true lengths carried with overrun
        queue_byte(8'h04, 1'b1, 17'd5);
        queue_byte(8'h10, 1'b0, 17'd5);
        // Too many length bytes: in the form byte, and after a nonzero first byte
        queue_byte(8'h30, 1'b1, 17'd65536);
        queue_byte(8'h86, 1'b0, 17'd65536);
        queue_byte(8'h30, 1'b1, 17'd65536);
        queue_byte(8'h85, 1'b0, 17'd65536);
        queue_byte(8'h01, 1'b0, 17'd65536);
        // Leading zero length byte
        queue_byte(8'h30, 1'b1, 17'd300);
        queue_byte(8'h83, 1'b0, 17'd300);
        queue_byte(8'h00, 1'b0, 17'd300);
        queue_byte(8'h01, 1'b0, 17'd300);
        queue_byte(8'h00, 1'b0, 17'd300);
        // Total overflows 32 bits
        queue_byte(8'h30, 1'b1, 17'd65536);
        queue_byte(8'h84, 1'b0, 17'd65536);
        repeat (4) queue_byte(8'hff, 1'b0, 17'd65536);
        // Tag too long
        queue_byte(8'hff, 1'b1, 17'd65536);
        repeat (5) queue_byte(8'h80, 1'b0, 17'd65536);

        while (stimulus_count < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                // Stray bytes, mostly without frame_start
                k = $urandom_range(1, 3);
                repeat (k) queue_byte(8'($urandom), 1'b0, 17'($urandom));
                if ($urandom_range(0, 1))
                    queue_byte(8'($urandom), 1'b1, 17'($urandom));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    cnt = 17'($urandom_range(200, BUFFER_BYTES));
                else if (r < 70)
                    cnt = 17'(BUFFER_BYTES);
                else if (r < 80)
                    cnt = 17'($urandom_range(BUFFER_BYTES + 1, 17'h1ffff));
                else if (r < 90)
                    cnt = 17'($urandom_range(0, 12));
                else
                    cnt = 17'($urandom_range(0, 300));

                if ($urandom_range(0, 4) == 0)
                begin
                    b = 8'($urandom);
                    queue_byte({b[7:5], 5'h1f}, 1'b1, cnt);
                    k = $urandom_range(0, 5);
                    repeat (k) queue_byte(8'h80 | 8'($urandom), 1'b0, cnt);
                    queue_byte(8'h7f & 8'($urandom), 1'b0, cnt);
                end
                else
                begin
                    b = 8'($urandom);
                    if (b[4:0] == 5'h1f)
                        b[4:0] = 5'($urandom_range(0, 30));
                    queue_byte(b, 1'b1, cnt);
                end

                r = $urandom_range(0, 99);
                if (r < 45)
                    queue_byte(8'($urandom_range(0, 127)), 1'b0, cnt);
                else if (r < 85)
                begin
                    n  = $urandom_range(1, MAX_LENGTH_BYTES);
                    lz = ($urandom_range(0, 3) == 0);
                    queue_byte(8'h80 | 8'(n + lz), 1'b0, cnt);
                    if (lz)
                        queue_byte(8'h00, 1'b0, cnt);
                    queue_byte(8'(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 3)),
                               1'b0, cnt);
                    repeat (n - 1) queue_byte(8'($urandom), 1'b0, cnt);
                end
                else
                begin
                    // Broken length forms; a truncated one is cut off by the next frame_start
                    case ($urandom_range(0, 3))
                        0: queue_byte(btlv_pkg::LEN_LONG_FORM, 1'b0, cnt);
                        1: queue_byte(btlv_pkg::LEN_RESERVED, 1'b0, cnt);
                        2:
                        begin
                            queue_byte(8'h80 | 8'($urandom_range(5, 7)), 1'b0, cnt);
                            k = $urandom_range(0, 5);
                            repeat (k) queue_byte(8'($urandom), 1'b0, cnt);
                        end
                        default:
                        begin
                            queue_byte(8'h80 | 8'($urandom_range(2, 5)), 1'b0, cnt);
                            queue_byte(8'($urandom), 1'b0, cnt);
                        end
                    endcase
                end
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_valid || headers_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (headers_due.size() != 0)
        begin
            $error("%0d expected results never arrived", headers_due.size());
            error_count++;
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
